// File: hdl/rdd_pkg.sv
// Package for the resource deadlock detector.
// Holds field widths, command and status codes, and the item and result structs.
// No dependencies.
`timescale 1ns / 1ps

package rdd_pkg;

    // Default table sizes for the top-level parameters.
    localparam int NUM_RESOURCES_DEF = 8;
    localparam int NUM_THREADS_DEF   = 16;

    // Fixed field widths of the stream words.
    localparam int ID_W        = 4;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic
    {
        CMD_REQUEST = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STS_GRANTED   = 3'd0,
        STS_WAITING   = 3'd1,
        STS_DEADLOCK  = 3'd2,
        STS_RELEASED  = 3'd3,
        STS_NOT_OWNER = 3'd4,
        STS_BAD_RES   = 3'd5
    } status_t;

    // One input word.
    typedef struct packed
    {
        cmd_t            command;
        logic [ID_W-1:0] thread_num;
        logic [ID_W-1:0] res_num;
    } item_t;

    // One result word.
    typedef struct packed
    {
        status_t         status;
        logic            handover_valid;
        logic [ID_W-1:0] handover_thread;
    } result_t;

endpackage

// File: hdl/rdd_core.sv
// Command engine of the resource deadlock detector: owner and pending memories,
// valid bits, and the sequencer that walks the wait-for chain and scans waiters.
// Depends on rdd_pkg.
`timescale 1ns / 1ps

module rdd_core #(
    parameter int NUM_RESOURCES = rdd_pkg::NUM_RESOURCES_DEF,
    parameter int NUM_THREADS   = rdd_pkg::NUM_THREADS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rdd_pkg::item_t   in_item,
    output logic             res_valid,
    input  logic             res_ready,
    output rdd_pkg::result_t res_word
);

    import rdd_pkg::*;

    localparam int RES_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int THR_W = $clog2(NUM_THREADS);
    localparam int HOP_W = $clog2(NUM_THREADS + 1);

    typedef enum logic [5:0]
    {
        ST_IDLE = 6'b000001,
        ST_OWN  = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_PEND = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [ID_W-1:0]          thr_reg, thr_next;
    logic [RES_W-1:0]         res_reg, res_next;
    logic [HOP_W-1:0]         hop_reg, hop_next;
    logic [THR_W-1:0]         idx_reg, idx_next;
    result_t                  result_reg, result_next;
    logic [NUM_RESOURCES-1:0] own_valid_reg, own_valid_next;
    logic [NUM_THREADS-1:0]   pend_valid_reg, pend_valid_next;

    // Owner memory: owning thread per resource.
    logic [THR_W-1:0] own_mem [NUM_RESOURCES];
    logic             own_we;
    logic [RES_W-1:0] own_wa;
    logic [THR_W-1:0] own_wd;
    logic             own_re;
    logic [RES_W-1:0] own_ra;
    logic [THR_W-1:0] own_rd_data_reg;

    // Pending memory: awaited resource per thread.
    logic [RES_W-1:0] pend_mem [NUM_THREADS];
    logic             pend_we;
    logic [THR_W-1:0] pend_wa;
    logic [RES_W-1:0] pend_wd;
    logic             pend_re;
    logic [THR_W-1:0] pend_ra;
    logic [RES_W-1:0] pend_rd_data_reg;

    logic             res_bad;
    logic             thr_ok;
    logic [THR_W-1:0] thr_idx;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_word  = result_reg;

    assign res_bad = ({1'b0, in_item.res_num} >= (ID_W + 1)'(NUM_RESOURCES));
    assign thr_ok  = ({1'b0, thr_reg} < (ID_W + 1)'(NUM_THREADS));
    assign thr_idx = thr_reg[THR_W-1:0];

    // Memory ports with registered read data.
    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[own_wa] <= own_wd;
        end
        if (own_re)
        begin
            own_rd_data_reg <= own_mem[own_ra];
        end
        if (pend_we)
        begin
            pend_mem[pend_wa] <= pend_wd;
        end
        if (pend_re)
        begin
            pend_rd_data_reg <= pend_mem[pend_ra];
        end
    end

    // Control and valid-bit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            own_valid_reg  <= '0;
            pend_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            own_valid_reg  <= own_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Item payload and walk counters.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        thr_reg    <= thr_next;
        res_reg    <= res_next;
        hop_reg    <= hop_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    // Sequencer: owner lookup, chain walk, waiter scan.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        thr_next        = thr_reg;
        res_next        = res_reg;
        hop_next        = hop_reg;
        idx_next        = idx_reg;
        result_next     = result_reg;
        own_valid_next  = own_valid_reg;
        pend_valid_next = pend_valid_reg;
        own_we          = 1'b0;
        own_wa          = res_reg;
        own_wd          = thr_idx;
        own_re          = 1'b0;
        own_ra          = res_reg;
        pend_we         = 1'b0;
        pend_wa         = thr_idx;
        pend_wd         = res_reg;
        pend_re         = 1'b0;
        pend_ra         = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in_item.command;
                    thr_next = in_item.thread_num;
                    res_next = in_item.res_num[RES_W-1:0];
                    if (res_bad)
                    begin
                        result_next = '{STS_BAD_RES, 1'b0, '0};
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        own_re     = 1'b1;
                        own_ra     = in_item.res_num[RES_W-1:0];
                        state_next = ST_OWN;
                    end
                end
            end

            ST_OWN:
            begin
                if (cmd_reg == CMD_REQUEST)
                begin
                    if (!thr_ok)
                    begin
                        result_next = '{STS_BAD_RES, 1'b0, '0};
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        // Any request drops the thread's old pending entry.
                        pend_valid_next[thr_idx] = 1'b0;
                        if (!own_valid_reg[res_reg])
                        begin
                            own_valid_next[res_reg] = 1'b1;
                            own_we                  = 1'b1;
                            result_next             = '{STS_GRANTED, 1'b0, '0};
                            state_next              = ST_DONE;
                        end
                        else if (own_rd_data_reg == thr_idx)
                        begin
                            result_next = '{STS_GRANTED, 1'b0, '0};
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            pend_valid_next[thr_idx] = 1'b1;
                            pend_we                  = 1'b1;
                            hop_next                 = '0;
                            state_next               = ST_CHK;
                        end
                    end
                end
                else
                begin
                    if (!own_valid_reg[res_reg] || !thr_ok || own_rd_data_reg != thr_idx)
                    begin
                        result_next = '{STS_NOT_OWNER, 1'b0, '0};
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        pend_re    = 1'b1;
                        pend_ra    = '0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            // The thread in own_rd_data_reg is the current node of the chain.
            ST_CHK:
            begin
                if (hop_reg == HOP_W'(NUM_THREADS))
                begin
                    result_next = '{STS_WAITING, 1'b0, '0};
                    state_next  = ST_DONE;
                end
                else if (own_rd_data_reg == thr_idx)
                begin
                    result_next = '{STS_DEADLOCK, 1'b0, '0};
                    state_next  = ST_DONE;
                end
                else if (!pend_valid_reg[own_rd_data_reg])
                begin
                    result_next = '{STS_WAITING, 1'b0, '0};
                    state_next  = ST_DONE;
                end
                else
                begin
                    pend_re    = 1'b1;
                    pend_ra    = own_rd_data_reg;
                    state_next = ST_PEND;
                end
            end

            // The resource the current node waits on; fetch its owner.
            ST_PEND:
            begin
                if (!own_valid_reg[pend_rd_data_reg])
                begin
                    result_next = '{STS_WAITING, 1'b0, '0};
                    state_next  = ST_DONE;
                end
                else
                begin
                    own_re     = 1'b1;
                    own_ra     = pend_rd_data_reg;
                    hop_next   = hop_reg + 1'b1;
                    state_next = ST_CHK;
                end
            end

            // One waiter per cycle, lowest thread first; next read overlaps the compare.
            ST_SCAN:
            begin
                if (pend_valid_reg[idx_reg] && pend_rd_data_reg == res_reg)
                begin
                    own_we                   = 1'b1;
                    own_wd                   = idx_reg;
                    pend_valid_next[idx_reg] = 1'b0;
                    result_next              = '{STS_RELEASED, 1'b1, ID_W'(idx_reg)};
                    state_next               = ST_DONE;
                end
                else if (idx_reg == THR_W'(NUM_THREADS - 1))
                begin
                    own_valid_next[res_reg] = 1'b0;
                    result_next             = '{STS_RELEASED, 1'b0, '0};
                    state_next              = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    pend_re  = 1'b1;
                    pend_ra  = idx_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/resource_deadlock_detector.sv
// Top level of the resource deadlock detector: stream ports and output register.
// Depends on rdd_pkg and rdd_core.
`timescale 1ns / 1ps

// The block keeps one owner per resource and at most one pending request per
// thread, and answers each command word with one result word. It works on one
// word at a time. A word with a bad resource goes straight to its result. A
// grant, a release refused or a bad thread first passes the owner lookup. A
// request that waits walks the wait-for chain with two memory reads per hop (one
// of the pending memory, one of the owner memory), for at most NUM_THREADS hops.
// A release by the owner scans the pending memory one thread per cycle, lowest
// thread first, and stops at the first waiter or after the last thread when
// nobody waits. A new word is taken in the cycle after the previous result
// moves to the output register, which holds it until the master side takes
// it. No clearing pass is needed after reset.

module resource_deadlock_detector #(
    parameter int NUM_RESOURCES = rdd_pkg::NUM_RESOURCES_DEF,
    parameter int NUM_THREADS   = rdd_pkg::NUM_THREADS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: thread_num[3:0], res_num[7:4].
    input  logic [rdd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // Fields: command (0 request, 1 release).
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: status[2:0], handover_thread[6:3], zero pad [7].
    output logic [rdd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Fields: handover_valid.
    output logic                           m_axis_tuser
);

    import rdd_pkg::*;

    item_t   in_item;
    result_t core_word;
    logic    core_valid;
    logic    core_ready;
    result_t out_reg;
    logic    out_valid_reg;

    assign in_item.command    = cmd_t'(s_axis_tuser);
    assign in_item.thread_num = s_axis_tdata[ID_W-1:0];
    assign in_item.res_num    = s_axis_tdata[2*ID_W-1:ID_W];

    rdd_core #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .NUM_THREADS   (NUM_THREADS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .res_word  (core_word)
    );

    // The output register takes a result whenever it is empty or being emptied.
    assign core_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_ready)
        begin
            out_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_ready && core_valid)
        begin
            out_reg <= core_word;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.handover_thread, out_reg.status};
    assign m_axis_tuser  = out_reg.handover_valid;

endmodule
